/* src/ddo_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and tables for the differential-drive odometry block.
// No dependencies; compiled first.
package ddo_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXLE_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 2'd2;

    localparam logic [15:0] RST_WHEEL_RADIUS = 16'd3277;
    localparam logic [15:0] RST_AXLE_LENGTH  = 16'd1229;
    localparam logic [15:0] RST_TIME_STEP    = 16'd6554;

    // Datapath widths
    localparam int unsigned MW = 64;           // magnitude path of mul/div
    localparam int unsigned CW = 34;           // CORDIC x/y/z
    localparam int unsigned TW = 31;           // sine/cosine, Q1.29 clamped
    localparam int unsigned CORDIC_STEPS = 24;

    localparam logic [25:0] INV_TWO_PI_Q28 = 26'd42722830;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

    typedef logic [MW-1:0] t_word;
    typedef logic signed [TW-1:0] t_trig;

    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word p;
    } t_mul_rsp;

    typedef struct packed {
        logic  start;
        t_word num;
        t_word den;
    } t_div_req;

    typedef struct packed {
        logic  done;
        t_word q;
    } t_div_rsp;

    typedef struct packed {
        logic        start;
        logic [15:0] angle;
    } t_cor_req;

    typedef struct packed {
        logic  done;
        t_trig sn;
        t_trig cs;
    } t_cor_rsp;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

/* src/ddo_ifs.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces: wheel-rate input, pose output, config writes.
// Depends on ddo_pkg.
interface ddo_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_rate;
    logic signed [15:0] right_rate;
    modport source (output valid, left_rate, right_rate, input ready);
    modport sink   (input valid, left_rate, right_rate, output ready);
endinterface

interface ddo_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    modport source (output valid, pos_x, pos_y, heading, input ready);
    modport sink   (input valid, pos_x, pos_y, heading, output ready);
endinterface

interface ddo_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ddo_pkg::CFG_IDX_W-1:0]  index;
    logic [15:0]                    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/ddo_mul.sv */
`timescale 1ns / 1ps
// Bit-serial unsigned shift-add multiplier: one multiplier bit per cycle,
// stops early once the remaining multiplier bits are zero. Depends on ddo_pkg.
module ddo_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ddo_pkg::t_mul_req i_req,
    output ddo_pkg::t_mul_rsp o_rsp
);
    import ddo_pkg::*;

    logic  r_busy;
    t_word r_a;
    t_word r_b;
    t_word r_p;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (r_b == '0)) begin
            r_busy <= 1'b0;
        end
    end

    // shift-add step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
            r_p <= '0;
        end else if (r_busy && (r_b != '0)) begin
            if (r_b[0]) begin
                r_p <= r_p + r_a;
            end
            r_a <= r_a << 1;
            r_b <= r_b >> 1;
        end
    end

    assign o_rsp.done = r_busy && (r_b == '0);
    assign o_rsp.p    = r_p;

endmodule

/* src/ddo_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle, producing an MW-bit quotient.
// Depends on ddo_pkg.
module ddo_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ddo_pkg::t_div_req i_req,
    output ddo_pkg::t_div_rsp o_rsp
);
    import ddo_pkg::*;

    localparam int unsigned CNT_W = $clog2(MW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    t_word            r_num;
    t_word            r_den;
    t_word            r_q;
    logic [MW:0]      r_rem;

    logic [MW:0] rem_sh;
    logic [MW:0] rem_sub;
    logic        fits;
    logic        run;

    assign run     = r_busy && (r_cnt != CNT_W'(MW));
    assign rem_sh  = {r_rem[MW-1:0], r_num[MW-1]};
    assign fits    = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (run) begin
            r_cnt <= r_cnt + 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    // one restoring step
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
            r_q   <= '0;
        end else if (run) begin
            r_rem <= fits ? rem_sub : rem_sh;
            r_num <= r_num << 1;
            r_q   <= {r_q[MW-2:0], fits};
        end
    end

    assign o_rsp.done = r_busy && (r_cnt == CNT_W'(MW));
    assign o_rsp.q    = r_q;

endmodule

/* src/ddo_cordic.sv */
`timescale 1ns / 1ps
// Rotation-mode CORDIC, one micro-rotation per cycle, for sine and cosine of a
// 16-bit binary angle. Quadrant fold, Q1.29 rounding and clamp. Depends on ddo_pkg.
module ddo_cordic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ddo_pkg::t_cor_req i_req,
    output ddo_pkg::t_cor_rsp o_rsp
);
    import ddo_pkg::*;

    localparam logic signed [CW-1:0] LIM = CW'(1) <<< 29;

    logic                 r_busy;
    logic [4:0]           r_i;
    logic [1:0]           r_quad;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;

    logic [31:0]          phase;
    logic [31:0]          ph_add;
    logic [31:0]          res;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [CW-1:0] at;
    logic signed [CW-1:0] c_rnd;
    logic signed [CW-1:0] s_rnd;
    logic signed [CW-1:0] cs_m;
    logic signed [CW-1:0] sn_m;
    logic signed [CW-1:0] cs_c;
    logic signed [CW-1:0] sn_c;

    // round half away from zero of v/2
    function automatic logic signed [CW-1:0] half_rnd(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] m;
        m = v[CW-1] ? -v : v;
        m = (m + 1) >>> 1;
        return v[CW-1] ? -m : m;
    endfunction

    function automatic logic signed [CW-1:0] clamp(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] c;
        c = v;
        if (v > LIM) begin
            c = LIM;
        end else if (v < -LIM) begin
            c = -LIM;
        end
        return c;
    endfunction

    // quadrant fold of the start angle
    assign phase  = {i_req.angle, 16'h0000};
    assign ph_add = phase + 32'h2000_0000;
    assign res    = phase - {ph_add[31:30], 30'd0};

    // micro-rotation operands
    assign xs = r_x >>> r_i;
    assign ys = r_y >>> r_i;
    assign at = signed'({2'b00, atan_turn(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy && (r_i != 5'(CORDIC_STEPS))) begin
            r_i <= r_i + 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quad <= ph_add[31:30];
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= CW'(signed'(res));
        end else if (r_busy && (r_i != 5'(CORDIC_STEPS))) begin
            if (!r_z[CW-1]) begin
                r_x <= r_x - ys;
                r_y <= r_y + xs;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + ys;
                r_y <= r_y - xs;
                r_z <= r_z + at;
            end
        end
    end

    // unfold quadrant, round and clamp
    assign c_rnd = half_rnd(r_x);
    assign s_rnd = half_rnd(r_y);

    always_comb begin
        case (r_quad)
            2'd0: begin
                cs_m = c_rnd;
                sn_m = s_rnd;
            end
            2'd1: begin
                cs_m = -s_rnd;
                sn_m = c_rnd;
            end
            2'd2: begin
                cs_m = -c_rnd;
                sn_m = -s_rnd;
            end
            default: begin
                cs_m = s_rnd;
                sn_m = -c_rnd;
            end
        endcase
    end

    assign cs_c = clamp(cs_m);
    assign sn_c = clamp(sn_m);

    assign o_rsp.done = r_busy && (r_i == 5'(CORDIC_STEPS));
    assign o_rsp.cs   = cs_c[TW-1:0];
    assign o_rsp.sn   = sn_c[TW-1:0];

endmodule

/* src/diff_drive_odometry_exact.sv */
`timescale 1ns / 1ps
// Differential-drive odometry, exact arc update; top level with the sequencer.
// Work is shared by the 64-step serial divider (one run for a straight step, three
// for an arc step), the bit-serial multiplies and the 24-step CORDIC (one or two
// runs). One item at a time: a new item is accepted only in the idle state, and a
// finished pose waits in the output register while the next item is accepted.
// Reset (synchronous, active low): pose to zero, registers to their defaults.
module diff_drive_odometry_exact (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ddo_in_if.sink    i_in,
    ddo_out_if.source o_out,
    ddo_cfg_if.sink   i_cfg
);
    import ddo_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_RD   = 5'd1;
    localparam logic [4:0] S_RDT  = 5'd2;
    localparam logic [4:0] S_ANG  = 5'd3;
    localparam logic [4:0] S_DEL  = 5'd4;
    localparam logic [4:0] S_COR1 = 5'd5;
    localparam logic [4:0] S_RS   = 5'd6;
    localparam logic [4:0] S_RST  = 5'd7;
    localparam logic [4:0] S_DCX  = 5'd8;
    localparam logic [4:0] S_DSY  = 5'd9;
    localparam logic [4:0] S_COR2 = 5'd10;
    localparam logic [4:0] S_SL   = 5'd11;
    localparam logic [4:0] S_AXN  = 5'd12;
    localparam logic [4:0] S_AXD  = 5'd13;
    localparam logic [4:0] S_AYN  = 5'd14;
    localparam logic [4:0] S_AYD  = 5'd15;
    localparam logic [4:0] S_UPD  = 5'd16;
    localparam logic [4:0] S_OUT  = 5'd17;

    localparam logic signed [MW:0] SAT_MAX = (MW+1)'(33'sh0_7FFF_FFFF);
    localparam logic signed [MW:0] SAT_MIN = -SAT_MAX - 1;

    logic [4:0]         r_state;
    logic               r_go;
    logic [15:0]        r_wr;
    logic [15:0]        r_al;
    logic [15:0]        r_ts;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;
    logic [15:0]        r_head;
    logic               r_ssgn;
    logic [16:0]        r_smag;
    logic               r_dsgn;
    logic [16:0]        r_dmag;
    t_word              r_t;
    t_word              r_sl;
    logic [15:0]        r_delta;
    logic               r_dzero;
    t_trig              r_s1;
    t_trig              r_c1;
    t_trig              r_s2;
    t_trig              r_c2;
    t_word              r_dx;
    t_word              r_dy;
    logic               r_out_valid;
    logic signed [31:0] r_ox;
    logic signed [31:0] r_oy;
    logic [15:0]        r_oh;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_cor_req cor_req;
    t_cor_rsp cor_rsp;

    logic               in_acc;
    logic signed [16:0] s_in;
    logic signed [16:0] d_in;
    logic [15:0]        len;
    logic [TW-1:0]      c1_mag;
    logic [TW-1:0]      s1_mag;
    logic signed [31:0] ds;
    logic signed [31:0] dc;
    logic [31:0]        ds_mag;
    logic [31:0]        dc_mag;
    t_word              rnd28;
    t_word              rnd27;
    t_word              rnd29;
    logic signed [MW:0] sum_x;
    logic signed [MW:0] sum_y;
    logic               out_load;

    ddo_mul    u_mul (.i_clk, .i_rst_n, .i_req(mul_req), .o_rsp(mul_rsp));
    ddo_div    u_div (.i_clk, .i_rst_n, .i_req(div_req), .o_rsp(div_rsp));
    ddo_cordic u_cor (.i_clk, .i_rst_n, .i_req(cor_req), .o_rsp(cor_rsp));

    function automatic t_word apply_sign(input logic neg, input t_word m);
        return neg ? (~m + 1'b1) : m;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [MW:0] v);
        logic signed [31:0] o;
        if (v > SAT_MAX) begin
            o = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            o = 32'sh8000_0000;
        end else begin
            o = v[31:0];
        end
        return o;
    endfunction

    // handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid   = r_out_valid;
    assign o_out.pos_x   = r_ox;
    assign o_out.pos_y   = r_oy;
    assign o_out.heading = r_oh;

    // input sum and difference
    assign s_in = 17'(i_in.left_rate) + 17'(i_in.right_rate);
    assign d_in = 17'(i_in.right_rate) - 17'(i_in.left_rate);
    assign len  = (r_al == '0) ? 16'd1 : r_al;

    // magnitudes and trig differences
    assign c1_mag = r_c1[TW-1] ? TW'(-r_c1) : TW'(r_c1);
    assign s1_mag = r_s1[TW-1] ? TW'(-r_s1) : TW'(r_s1);
    assign ds     = 32'(r_s2) - 32'(r_s1);
    assign dc     = 32'(r_c1) - 32'(r_c2);
    assign ds_mag = ds[31] ? 32'(-ds) : 32'(ds);
    assign dc_mag = dc[31] ? 32'(-dc) : 32'(dc);

    // power-of-two rounding of the multiplier result
    assign rnd28 = (mul_rsp.p + (t_word'(1) << 27)) >> 28;
    assign rnd27 = (mul_rsp.p + (t_word'(1) << 26)) >> 27;
    assign rnd29 = (mul_rsp.p + (t_word'(1) << 28)) >> 29;

    // saturating pose add
    assign sum_x = (MW+1)'(r_pos_x) + signed'({r_dx[MW-1], r_dx});
    assign sum_y = (MW+1)'(r_pos_y) + signed'({r_dy[MW-1], r_dy});

    // unit requests by state
    always_comb begin
        mul_req = '0;
        div_req = '0;
        cor_req = '0;
        unique case (r_state)
            S_RD: begin
                mul_req.a = MW'(r_wr);
                mul_req.b = MW'(r_dmag);
            end
            S_RDT, S_RST: begin
                mul_req.a = r_t;
                mul_req.b = MW'(r_ts);
            end
            S_DEL: begin
                mul_req.a = r_t;
                mul_req.b = MW'(INV_TWO_PI_Q28);
            end
            S_RS: begin
                mul_req.a = MW'(r_wr);
                mul_req.b = MW'(r_smag);
            end
            S_DCX: begin
                mul_req.a = r_t;
                mul_req.b = MW'(c1_mag);
            end
            S_DSY: begin
                mul_req.a = r_t;
                mul_req.b = MW'(s1_mag);
            end
            S_SL: begin
                mul_req.a = MW'(r_smag);
                mul_req.b = MW'(len);
            end
            S_AXN: begin
                mul_req.a = r_sl;
                mul_req.b = MW'(ds_mag);
            end
            S_AYN: begin
                mul_req.a = r_sl;
                mul_req.b = MW'(dc_mag);
            end
            S_ANG: begin
                div_req.num = r_t + (MW'(len) << 13);
                div_req.den = MW'(len) << 14;
            end
            S_AXD, S_AYD: begin
                div_req.num = r_t + (MW'(r_dmag) << 25);
                div_req.den = MW'(r_dmag) << 26;
            end
            S_COR1: cor_req.angle = r_head;
            S_COR2: cor_req.angle = r_head + r_delta;
            default: ;
        endcase
        mul_req.start = !r_go && (r_state == S_RD || r_state == S_RDT || r_state == S_DEL ||
                        r_state == S_RS || r_state == S_RST || r_state == S_DCX ||
                        r_state == S_DSY || r_state == S_SL || r_state == S_AXN ||
                        r_state == S_AYN);
        div_req.start = !r_go && (r_state == S_ANG || r_state == S_AXD || r_state == S_AYD);
        cor_req.start = !r_go && (r_state == S_COR1 || r_state == S_COR2);
    end

    assign out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= RST_WHEEL_RADIUS;
            r_al <= RST_AXLE_LENGTH;
            r_ts <= RST_TIME_STEP;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_WHEEL_RADIUS: r_wr <= i_cfg.data;
                REG_AXLE_LENGTH:  r_al <= i_cfg.data;
                REG_TIME_STEP:    r_ts <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // sequencer and pose state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (mul_req.start || div_req.start || cor_req.start) begin
                r_go <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: if (in_acc) begin
                    r_state <= S_RD;
                end
                S_RD: if (mul_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_RDT;
                end
                S_RDT: if (mul_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_ANG;
                end
                S_ANG: if (div_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_DEL;
                end
                S_DEL: if (mul_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_COR1;
                end
                S_COR1: if (cor_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= r_dzero ? S_RS : S_COR2;
                end
                S_RS: if (mul_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_RST;
                end
                S_RST: if (mul_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_DCX;
                end
                S_DCX: if (mul_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_DSY;
                end
                S_DSY: if (mul_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_UPD;
                end
                S_COR2: if (cor_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_SL;
                end
                S_SL: if (mul_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_AXN;
                end
                S_AXN: if (mul_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_AXD;
                end
                S_AXD: if (div_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_AYN;
                end
                S_AYN: if (mul_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_AYD;
                end
                S_AYD: if (div_rsp.done && r_go) begin
                    r_go <= 1'b0; r_state <= S_UPD;
                end
                S_UPD: begin
                    r_pos_x <= sat32(sum_x);
                    r_pos_y <= sat32(sum_y);
                    if (!r_dzero) begin
                        r_head <= r_head + r_delta;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: if (out_load) begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath capture
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ssgn <= s_in[16];
            r_smag <= s_in[16] ? 17'(-s_in) : 17'(s_in);
            r_dsgn <= d_in[16];
            r_dmag <= d_in[16] ? 17'(-d_in) : 17'(d_in);
        end
        if (mul_rsp.done && r_go) begin
            case (r_state)
                S_RD, S_RDT, S_RS, S_AXN, S_AYN: r_t <= mul_rsp.p;
                S_DEL: begin
                    r_delta <= r_dsgn ? 16'(-rnd28[15:0]) : rnd28[15:0];
                    r_dzero <= (rnd28 == '0);
                end
                S_RST: r_t  <= rnd27;
                S_DCX: r_dx <= apply_sign(r_ssgn ^ r_c1[TW-1], rnd29);
                S_DSY: r_dy <= apply_sign(r_ssgn ^ r_s1[TW-1], rnd29);
                S_SL:  r_sl <= mul_rsp.p;
                default: ;
            endcase
        end
        if (div_rsp.done && r_go) begin
            case (r_state)
                S_ANG: r_t  <= div_rsp.q;
                S_AXD: r_dx <= apply_sign(r_ssgn ^ r_dsgn ^ ds[31], div_rsp.q);
                S_AYD: r_dy <= apply_sign(r_ssgn ^ r_dsgn ^ dc[31], div_rsp.q);
                default: ;
            endcase
        end
        if (cor_rsp.done && r_go) begin
            if (r_state == S_COR1) begin
                r_s1 <= cor_rsp.sn;
                r_c1 <= cor_rsp.cs;
            end else begin
                r_s2 <= cor_rsp.sn;
                r_c2 <= cor_rsp.cs;
            end
        end
        if (out_load) begin
            r_ox <= r_pos_x;
            r_oy <= r_pos_y;
            r_oh <= r_head;
        end
    end

`ifndef SYNTHESIS
    a_accept_no_unit_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> !r_go)
        else $error("item accepted while a unit run is pending");

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_OUT)
        else $error("result presented outside the output state");

    a_head_only_on_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_UPD) |=> $stable(r_head))
        else $error("heading changed outside the pose update");

    a_single_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({mul_req.start, div_req.start, cor_req.start}) <= 1)
        else $error("two arithmetic units started together");
`endif

endmodule
